FILE: sv/cpi_pkg.sv
`timescale 1ns / 1ps
// Package for the CIGAR interval parser: parse modes, result codes,
// operator codes, character constants and the step status struct.
// No dependencies.
package cpi_pkg;

  localparam int LEN_WIDTH = 31;

  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_LEAD,
    MODE_COUNT,
    MODE_AFTER_OP,
    MODE_TRAIL,
    MODE_HALT
  } mode_t;

  typedef enum logic [1:0] {
    KIND_OP,
    KIND_END,
    KIND_ERR
  } kind_t;

  typedef enum logic [1:0] {
    OP_MATCH,
    OP_INSERT,
    OP_DELETE,
    OP_SOFT_CLIP
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_CHAR,
    ERR_OVERFLOW,
    ERR_DANGLING
  } err_t;

  typedef struct packed {
    logic  emit;
    kind_t kind;
    op_t   op_type;
    err_t  err_code;
    logic  eos;
  } step_status_t;

endpackage

FILE: sv/cpi_text_if.sv
`timescale 1ns / 1ps
// Byte channel into the CIGAR interval parser: valid/ready plus one text byte.
// No dependencies.
interface cpi_text_if #(
  parameter int POS_WIDTH = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           char_byte;
  logic                 first_byte;
  logic                 last_byte;
  logic [POS_WIDTH-1:0] ref_start;

  modport source (output valid, char_byte, first_byte, last_byte, ref_start,
                  input ready);
  modport sink   (input valid, char_byte, first_byte, last_byte, ref_start,
                  output ready);
endinterface

FILE: sv/cpi_result_if.sv
`timescale 1ns / 1ps
// Result channel out of the CIGAR interval parser: valid/ready plus one result.
// No dependencies.
interface cpi_result_if #(
  parameter int POS_WIDTH = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [1:0]           op_type;
  logic [30:0]          op_length;
  logic [POS_WIDTH-1:0] query_begin;
  logic [POS_WIDTH-1:0] query_end;
  logic [POS_WIDTH-1:0] ref_begin;
  logic [POS_WIDTH-1:0] ref_end;
  logic                 end_of_string;
  logic [1:0]           error_code;

  modport source (output valid, result_kind, op_type, op_length, query_begin, query_end,
                  ref_begin, ref_end, end_of_string, error_code,
                  input ready);
  modport sink   (input valid, result_kind, op_type, op_length, query_begin, query_end,
                  ref_begin, ref_end, end_of_string, error_code,
                  output ready);
endinterface

FILE: sv/cpi_step.sv
`timescale 1ns / 1ps
// One parse step of the CIGAR interval parser: next state and result for one byte.
// Depends on cpi_pkg.
module cpi_step #(
  parameter int POS_WIDTH = 48
) (
  input  cpi_pkg::mode_t                  mode,
  input  logic [cpi_pkg::LEN_WIDTH-1:0]   acc,
  input  logic [POS_WIDTH-1:0]            qpos,
  input  logic [POS_WIDTH-1:0]            rpos,
  input  logic [7:0]                      char_byte,
  input  logic                            first_byte,
  input  logic                            last_byte,
  input  logic [POS_WIDTH-1:0]            ref_start,
  output cpi_pkg::mode_t                  mode_next,
  output logic [cpi_pkg::LEN_WIDTH-1:0]   acc_next,
  output logic [POS_WIDTH-1:0]            qpos_next,
  output logic [POS_WIDTH-1:0]            rpos_next,
  output cpi_pkg::step_status_t           status,
  output logic [cpi_pkg::LEN_WIDTH-1:0]   op_length,
  output logic [POS_WIDTH-1:0]            query_begin,
  output logic [POS_WIDTH-1:0]            query_end,
  output logic [POS_WIDTH-1:0]            ref_begin,
  output logic [POS_WIDTH-1:0]            ref_end
);

  localparam int LW = cpi_pkg::LEN_WIDTH;

  cpi_pkg::mode_t       mode_e;
  logic [LW-1:0]        acc_e;
  logic [POS_WIDTH-1:0] q_e;
  logic [POS_WIDTH-1:0] r_e;
  logic                 is_digit;
  logic                 is_space;
  logic                 op_hit;
  cpi_pkg::op_t         op_cls;
  logic [3:0]           digit;
  logic [LW+3:0]        acc_x10;
  logic [LW+3:0]        acc_dec;
  logic                 ovf;
  logic [POS_WIDTH-1:0] len_ext;
  logic                 halted;

  // A first byte restarts the string before the byte itself is parsed.
  assign mode_e = first_byte ? cpi_pkg::MODE_LEAD : mode;
  assign acc_e  = first_byte ? '0 : acc;
  assign q_e    = first_byte ? '0 : qpos;
  assign r_e    = first_byte ? ref_start : rpos;

  assign is_digit = (char_byte >= cpi_pkg::CH_ZERO) && (char_byte <= cpi_pkg::CH_NINE);
  assign is_space = (char_byte == cpi_pkg::CH_SPACE) ||
                    ((char_byte >= cpi_pkg::CH_TAB) && (char_byte <= cpi_pkg::CH_CR));
  assign digit    = char_byte[3:0];

  // acc * 10 + digit as shifts and adds; anything above 31 bits is overflow
  assign acc_x10 = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0};
  assign acc_dec = acc_x10 + {{(LW){1'b0}}, digit};
  assign ovf     = |acc_dec[LW+3:LW];
  assign len_ext = {{(POS_WIDTH-LW){1'b0}}, acc_e};

  always_comb begin
    op_hit = 1'b1;
    op_cls = cpi_pkg::OP_MATCH;
    case (char_byte)
      cpi_pkg::CH_M, cpi_pkg::CH_EQUAL, cpi_pkg::CH_X: op_cls = cpi_pkg::OP_MATCH;
      cpi_pkg::CH_I: op_cls = cpi_pkg::OP_INSERT;
      cpi_pkg::CH_D, cpi_pkg::CH_N: op_cls = cpi_pkg::OP_DELETE;
      cpi_pkg::CH_S: op_cls = cpi_pkg::OP_SOFT_CLIP;
      default: op_hit = 1'b0;
    endcase
  end

  always_comb begin
    mode_next       = mode_e;
    acc_next        = acc_e;
    qpos_next       = q_e;
    rpos_next       = r_e;
    status.emit     = 1'b0;
    status.kind     = cpi_pkg::KIND_END;
    status.op_type  = cpi_pkg::OP_MATCH;
    status.err_code = cpi_pkg::ERR_NONE;
    status.eos      = 1'b0;
    op_length       = '0;
    query_end       = q_e;
    ref_end         = r_e;
    halted          = 1'b0;

    case (mode_e)
      cpi_pkg::MODE_LEAD: begin
        if (is_digit) begin
          acc_next  = {{(LW-4){1'b0}}, digit};
          mode_next = cpi_pkg::MODE_COUNT;
        end else if (!is_space) begin
          status.emit     = 1'b1;
          status.kind     = cpi_pkg::KIND_ERR;
          status.err_code = cpi_pkg::ERR_CHAR;
        end
      end
      cpi_pkg::MODE_COUNT: begin
        if (is_digit) begin
          if (ovf) begin
            status.emit     = 1'b1;
            status.kind     = cpi_pkg::KIND_ERR;
            status.err_code = cpi_pkg::ERR_OVERFLOW;
          end else begin
            acc_next = acc_dec[LW-1:0];
          end
        end else if (op_hit) begin
          status.emit    = 1'b1;
          status.kind    = cpi_pkg::KIND_OP;
          status.op_type = op_cls;
          op_length      = acc_e;
          if (op_cls != cpi_pkg::OP_DELETE) begin
            query_end = q_e + len_ext;
          end
          if (op_cls == cpi_pkg::OP_MATCH || op_cls == cpi_pkg::OP_DELETE) begin
            ref_end = r_e + len_ext;
          end
          qpos_next = query_end;
          rpos_next = ref_end;
          acc_next  = '0;
          mode_next = cpi_pkg::MODE_AFTER_OP;
        end else begin
          status.emit     = 1'b1;
          status.kind     = cpi_pkg::KIND_ERR;
          status.err_code = is_space ? cpi_pkg::ERR_DANGLING : cpi_pkg::ERR_CHAR;
        end
      end
      cpi_pkg::MODE_AFTER_OP: begin
        if (is_digit) begin
          acc_next  = {{(LW-4){1'b0}}, digit};
          mode_next = cpi_pkg::MODE_COUNT;
        end else if (is_space) begin
          mode_next = cpi_pkg::MODE_TRAIL;
        end else begin
          status.emit     = 1'b1;
          status.kind     = cpi_pkg::KIND_ERR;
          status.err_code = cpi_pkg::ERR_CHAR;
        end
      end
      cpi_pkg::MODE_TRAIL: begin
        if (!is_space) begin
          status.emit     = 1'b1;
          status.kind     = cpi_pkg::KIND_ERR;
          status.err_code = cpi_pkg::ERR_CHAR;
        end
      end
      default: halted = 1'b1;
    endcase

    // Close the string on its last byte if nothing else was reported.
    if (last_byte && !status.emit && !halted) begin
      status.emit = 1'b1;
      if (mode_next == cpi_pkg::MODE_COUNT) begin
        status.kind     = cpi_pkg::KIND_ERR;
        status.err_code = cpi_pkg::ERR_DANGLING;
      end else begin
        status.kind = cpi_pkg::KIND_END;
      end
    end

    // Drop the rest of the string after an error or its last byte.
    if (status.emit && (status.kind == cpi_pkg::KIND_ERR || last_byte)) begin
      status.eos = 1'b1;
      mode_next  = cpi_pkg::MODE_HALT;
      acc_next   = '0;
    end
  end

  assign query_begin = q_e;
  assign ref_begin   = r_e;

endmodule

FILE: sv/cigar_parser_intervals.sv
`timescale 1ns / 1ps
// CIGAR string parser with query and reference intervals, one byte per cycle.
// A byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the parse step is one decode, one x10 add
// and two position adds between the input register and the result register.
// A byte that makes a result waits in the input register while the result
// register is full and not being taken.
// Reset (rst, synchronous): both stages empty, leading whitespace mode, count
// and positions zero.  Depends on cpi_pkg, cpi_text_if, cpi_result_if, cpi_step.
module cigar_parser_intervals #(
  parameter int POS_WIDTH = 48
) (
  input logic          clk,
  input logic          rst,
  cpi_text_if.sink     text,
  cpi_result_if.source result
);

  localparam int LW = cpi_pkg::LEN_WIDTH;

  // input register
  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_first;
  logic                 s1_last;
  logic [POS_WIDTH-1:0] s1_ref_start;

  // parse state
  cpi_pkg::mode_t       mode;
  cpi_pkg::mode_t       mode_next;
  logic [LW-1:0]        acc;
  logic [LW-1:0]        acc_next;
  logic [POS_WIDTH-1:0] qpos;
  logic [POS_WIDTH-1:0] qpos_next;
  logic [POS_WIDTH-1:0] rpos;
  logic [POS_WIDTH-1:0] rpos_next;

  cpi_pkg::step_status_t st;
  logic [LW-1:0]         st_len;
  logic [POS_WIDTH-1:0]  st_qb;
  logic [POS_WIDTH-1:0]  st_qe;
  logic [POS_WIDTH-1:0]  st_rb;
  logic [POS_WIDTH-1:0]  st_re;

  logic out_valid;
  logic out_free;
  logic s1_adv;

  cpi_step #(
    .POS_WIDTH (POS_WIDTH)
  ) u_step (
    .mode        (mode),
    .acc         (acc),
    .qpos        (qpos),
    .rpos        (rpos),
    .char_byte   (s1_char),
    .first_byte  (s1_first),
    .last_byte   (s1_last),
    .ref_start   (s1_ref_start),
    .mode_next   (mode_next),
    .acc_next    (acc_next),
    .qpos_next   (qpos_next),
    .rpos_next   (rpos_next),
    .status      (st),
    .op_length   (st_len),
    .query_begin (st_qb),
    .query_end   (st_qe),
    .ref_begin   (st_rb),
    .ref_end     (st_re)
  );

  assign out_free   = !out_valid || result.ready;
  // advance the held byte unless its result has nowhere to go
  assign s1_adv     = s1_valid && (!st.emit || out_free);
  assign text.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      s1_char      <= text.char_byte;
      s1_first     <= text.first_byte;
      s1_last      <= text.last_byte;
      s1_ref_start <= text.ref_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cpi_pkg::MODE_LEAD;
      acc  <= '0;
      qpos <= '0;
      rpos <= '0;
    end else if (s1_adv) begin
      mode <= mode_next;
      acc  <= acc_next;
      qpos <= qpos_next;
      rpos <= rpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && st.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && st.emit) begin
      result.result_kind   <= st.kind;
      result.op_type       <= st.op_type;
      result.op_length     <= st_len;
      result.query_begin   <= st_qb;
      result.query_end     <= st_qe;
      result.ref_begin     <= st_rb;
      result.ref_end       <= st_re;
      result.end_of_string <= st.eos;
      result.error_code    <= st.err_code;
    end
  end

  assign result.valid = out_valid;

  a_halt_after_eos: assert property (@(posedge clk) disable iff (rst)
    s1_adv && st.emit && st.eos |=> mode == cpi_pkg::MODE_HALT)
    else $error("parser not halted after end of string");

  a_err_ends_string: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.result_kind == cpi_pkg::KIND_ERR |-> result.end_of_string)
    else $error("error result without end of string");

  a_code_only_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.error_code != cpi_pkg::ERR_NONE
      |-> result.result_kind == cpi_pkg::KIND_ERR)
    else $error("error code on a non-error result");

  a_delete_no_query: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.result_kind == cpi_pkg::KIND_OP
      && result.op_type == cpi_pkg::OP_DELETE |-> result.query_end == result.query_begin)
    else $error("delete advanced the query");

endmodule

FILE: test/cigar_parser_intervals_test.sv
`timescale 1ns / 1ps
// Testbench for cigar_parser_intervals: feeds CIGAR text bytes, predicts each result
// with an interval scoreboard, and checks every result transfer field by field.
// Depends on cpi_pkg, cpi_text_if, cpi_result_if and the parser RTL.
module cigar_parser_intervals_test;

  localparam int POS_W = 48;
  localparam int RAND_BYTES = 2000;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint unsigned LEN_LIMIT = 64'h7FFF_FFFF;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    cpi_pkg::kind_t   kind;
    cpi_pkg::op_t     op;
    logic [30:0]      len;
    logic [POS_W-1:0] qb;
    logic [POS_W-1:0] qe;
    logic [POS_W-1:0] rb;
    logic [POS_W-1:0] re;
    logic             eos;
    cpi_pkg::err_t    err;
  } interval_result_t;

  class cigar_interval_scoreboard;
    cpi_pkg::mode_t   mode;
    logic [30:0]      count;
    logic [POS_W-1:0] qpos;
    logic [POS_W-1:0] rpos;
    interval_result_t expected_intervals[$];
    int               errors;
    int               checked;

    function new();
      mode = cpi_pkg::MODE_LEAD;
      count = '0;
      qpos = '0;
      rpos = '0;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_intervals.size();
    endfunction

    function bit classify_op(input logic [7:0] c, output cpi_pkg::op_t op);
      op = cpi_pkg::OP_MATCH;
      case (c)
        cpi_pkg::CH_M, cpi_pkg::CH_EQUAL, cpi_pkg::CH_X: op = cpi_pkg::OP_MATCH;
        cpi_pkg::CH_I: op = cpi_pkg::OP_INSERT;
        cpi_pkg::CH_D, cpi_pkg::CH_N: op = cpi_pkg::OP_DELETE;
        cpi_pkg::CH_S: op = cpi_pkg::OP_SOFT_CLIP;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Advance the parse state by one accepted byte; queue the result it causes.
    function void note_byte(logic [7:0] c, logic first, logic last, logic [POS_W-1:0] rs);
      interval_result_t r;
      bit               produce;
      bit               is_digit;
      bit               is_space;
      cpi_pkg::op_t     op;
      logic [63:0]      v;
      is_digit = (c >= cpi_pkg::CH_ZERO) && (c <= cpi_pkg::CH_NINE);
      is_space = (c == cpi_pkg::CH_SPACE) ||
                 ((c >= cpi_pkg::CH_TAB) && (c <= cpi_pkg::CH_CR));
      if (first) begin
        mode = cpi_pkg::MODE_LEAD;
        count = '0;
        qpos = '0;
        rpos = rs;
      end
      if (mode == cpi_pkg::MODE_HALT) return;
      r = '0;
      r.kind = cpi_pkg::KIND_OP;
      r.op = cpi_pkg::OP_MATCH;
      r.err = cpi_pkg::ERR_NONE;
      r.qb = qpos;
      r.qe = qpos;
      r.rb = rpos;
      r.re = rpos;
      produce = 1'b0;
      case (mode)
        cpi_pkg::MODE_LEAD: begin
          if (is_digit) begin
            count = 31'(c - cpi_pkg::CH_ZERO);
            mode = cpi_pkg::MODE_COUNT;
          end else if (!is_space) begin
            produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_CHAR;
          end
        end
        cpi_pkg::MODE_COUNT: begin
          if (is_digit) begin
            v = 64'(count) * 64'd10 + 64'(c - cpi_pkg::CH_ZERO);
            if (v > LEN_LIMIT) begin
              produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_OVERFLOW;
            end else begin
              count = v[30:0];
            end
          end else if (classify_op(c, op)) begin
            r.op = op;
            r.len = count;
            if (op != cpi_pkg::OP_DELETE) r.qe = r.qb + POS_W'(count);
            if (op == cpi_pkg::OP_MATCH || op == cpi_pkg::OP_DELETE) begin
              r.re = r.rb + POS_W'(count);
            end
            qpos = r.qe;
            rpos = r.re;
            count = '0;
            produce = 1'b1;
            mode = cpi_pkg::MODE_AFTER_OP;
          end else if (is_space) begin
            produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_DANGLING;
          end else begin
            produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_CHAR;
          end
        end
        cpi_pkg::MODE_AFTER_OP: begin
          if (is_digit) begin
            count = 31'(c - cpi_pkg::CH_ZERO);
            mode = cpi_pkg::MODE_COUNT;
          end else if (is_space) begin
            mode = cpi_pkg::MODE_TRAIL;
          end else begin
            produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_CHAR;
          end
        end
        default: begin
          if (!is_space) begin
            produce = 1'b1; r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_CHAR;
          end
        end
      endcase
      if (last && !produce) begin
        produce = 1'b1;
        if (mode == cpi_pkg::MODE_COUNT) begin
          r.kind = cpi_pkg::KIND_ERR; r.err = cpi_pkg::ERR_DANGLING;
        end else begin
          r.kind = cpi_pkg::KIND_END;
        end
      end
      if (!produce) return;
      if (r.kind == cpi_pkg::KIND_ERR || last) begin
        mode = cpi_pkg::MODE_HALT;
        count = '0;
        r.eos = 1'b1;
      end
      expected_intervals.insert(expected_intervals.size(), r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(interval_result_t got);
      interval_result_t exp;
      string            diffs;
      checked++;
      if (expected_intervals.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected, kind %0d",
                                  checked, got.kind));
        return;
      end
      exp = expected_intervals.pop_front();
      diffs = "";
      if (got.kind !== exp.kind) diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, exp.kind)};
      if (got.op !== exp.op) diffs = {diffs, $sformatf(" op %0d/%0d", got.op, exp.op)};
      if (got.len !== exp.len) diffs = {diffs, $sformatf(" len %0d/%0d", got.len, exp.len)};
      if (got.qb !== exp.qb) diffs = {diffs, $sformatf(" qb %h/%h", got.qb, exp.qb)};
      if (got.qe !== exp.qe) diffs = {diffs, $sformatf(" qe %h/%h", got.qe, exp.qe)};
      if (got.rb !== exp.rb) diffs = {diffs, $sformatf(" rb %h/%h", got.rb, exp.rb)};
      if (got.re !== exp.re) diffs = {diffs, $sformatf(" re %h/%h", got.re, exp.re)};
      if (got.eos !== exp.eos) diffs = {diffs, $sformatf(" eos %0d/%0d", got.eos, exp.eos)};
      if (got.err !== exp.err) diffs = {diffs, $sformatf(" err %0d/%0d", got.err, exp.err)};
      if (diffs != "") report_mismatch($sformatf("result %0d (got/exp):%s", checked, diffs));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   cycles;
  int   sent_bytes;
  logic [7:0] text_buf[$];
  cigar_interval_scoreboard sb;

  cpi_text_if #(.POS_WIDTH(POS_W)) text_ch ();
  cpi_result_if #(.POS_WIDTH(POS_W)) result_ch ();

  cigar_parser_intervals #(.POS_WIDTH(POS_W)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cigar_parser_intervals_test: done, errors");
      $finish;
    end
  end

  // Receiver: stall at random, except during the quiet stretch.
  always @(negedge clk) begin
    result_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin : result_monitor
    interval_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind = cpi_pkg::kind_t'(result_ch.result_kind);
      got.op   = cpi_pkg::op_t'(result_ch.op_type);
      got.len  = result_ch.op_length;
      got.qb   = result_ch.query_begin;
      got.qe   = result_ch.query_end;
      got.rb   = result_ch.ref_begin;
      got.re   = result_ch.ref_end;
      got.eos  = result_ch.end_of_string;
      got.err  = cpi_pkg::err_t'(result_ch.error_code);
      sb.check_result(got);
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom();
    hi = $urandom();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return '1 - POS_W'($urandom_range(0, 1000));
      default: return {hi[15:0], lo};
    endcase
  endfunction

  function automatic logic [7:0] rand_op_char();
    case ($urandom_range(0, 6))
      0: return cpi_pkg::CH_M;
      1: return cpi_pkg::CH_EQUAL;
      2: return cpi_pkg::CH_X;
      3: return cpi_pkg::CH_I;
      4: return cpi_pkg::CH_D;
      5: return cpi_pkg::CH_N;
      default: return cpi_pkg::CH_S;
    endcase
  endfunction

  function automatic void put_byte(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic void add_str(string s);
    foreach (s[i]) put_byte(s[i]);
  endfunction

  function automatic void add_ws(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: put_byte(cpi_pkg::CH_SPACE);
        1: put_byte(cpi_pkg::CH_TAB);
        2: put_byte(CH_LF);
        3: put_byte(CH_VT);
        4: put_byte(CH_FF);
        default: put_byte(cpi_pkg::CH_CR);
      endcase
    end
  endfunction

  function automatic void add_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) add_str("0");
    if (roll < 60) add_str($sformatf("%0d", $urandom_range(1, 50)));
    else if (roll < 80) add_str($sformatf("%0d", $urandom_range(0, 999)));
    else if (roll < 90) add_str($sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF)));
    else if (roll < 95) add_str($sformatf("%0d", LEN_LIMIT));
    else add_str("0");
  endfunction

  function automatic void add_ops(int n);
    for (int i = 0; i < n; i++) begin
      add_count();
      put_byte(rand_op_char());
    end
  endfunction

  function automatic void add_cigar();
    if ($urandom_range(0, 4) == 0) add_ws($urandom_range(1, 2));
    add_ops($urandom_range(1, 6));
    if ($urandom_range(0, 4) == 0) add_ws($urandom_range(1, 2));
  endfunction

  // Entered and left at a falling edge; hold valid across back-to-back transfers.
  task automatic send_byte(logic [7:0] c, logic first, logic last, logic [POS_W-1:0] rs);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.char_byte  <= c;
    text_ch.first_byte <= first;
    text_ch.last_byte  <= last;
    text_ch.ref_start  <= rs;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sb.note_byte(c, first, last, rs);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(bit with_first, bit with_last, logic [POS_W-1:0] rs);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      send_byte(text_buf[i], with_first && (i == 0), with_last && (i == n - 1),
                (i == 0) ? rs : rand_pos());
    end
    text_buf.delete();
  endtask

  task automatic send_str(string s, bit with_first, bit with_last, logic [POS_W-1:0] rs);
    add_str(s);
    send_text(with_first, with_last, rs);
  endtask

  task automatic drain();
    text_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_string();
    logic [POS_W-1:0] rs;
    rs = rand_pos();
    if ($urandom_range(0, 99) < 75) begin
      add_cigar();
      send_text(1'b1, 1'b1, rs);
      return;
    end
    case ($urandom_range(0, 7))
      0: begin  // raw noise over the whole byte range
        for (int i = $urandom_range(1, 8); i > 0; i--) put_byte(8'($urandom()));
        send_text(1'b1, 1'b1, rs);
      end
      1: begin  // count overflow
        if ($urandom_range(0, 1)) add_ops($urandom_range(1, 3));
        add_str($sformatf("%0d", LEN_LIMIT + 1 + longint'($urandom_range(0, 1000000))));
        add_ops(1);
        send_text(1'b1, 1'b1, rs);
      end
      2: begin  // string ends inside a count
        if ($urandom_range(0, 1)) add_ops($urandom_range(1, 3));
        add_count();
        send_text(1'b1, 1'b1, rs);
      end
      3: begin  // operator with no count
        if ($urandom_range(0, 1)) add_ops($urandom_range(1, 3));
        put_byte(rand_op_char());
        add_ops(1);
        send_text(1'b1, 1'b1, rs);
      end
      4: begin  // whitespace right after a count
        if ($urandom_range(0, 1)) add_ops($urandom_range(1, 3));
        add_count();
        add_ws(1);
        add_ops(1);
        send_text(1'b1, 1'b1, rs);
      end
      5: begin  // whitespace between operations
        add_ops($urandom_range(1, 3));
        add_ws($urandom_range(1, 2));
        add_ops($urandom_range(1, 2));
        send_text(1'b1, 1'b1, rs);
      end
      6: begin  // no last byte: the next first byte cuts it off
        add_cigar();
        if ($urandom_range(0, 1)) add_count();
        send_text(1'b1, 1'b0, rs);
      end
      default: begin  // bytes after the end, to be dropped
        add_cigar();
        send_text(1'b1, 1'b1, rs);
        for (int i = $urandom_range(1, 4); i > 0; i--) put_byte(8'($urandom()));
        send_text(1'b0, 1'($urandom_range(0, 1)), rand_pos());
      end
    endcase
  endtask

  initial begin : stimulus
    bit drained;
    int target;
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    cycles = 0;
    sent_bytes = 0;
    drained = 1'b0;
    text_ch.valid = 1'b0;
    text_ch.char_byte = '0;
    text_ch.first_byte = 1'b0;
    text_ch.last_byte = 1'b0;
    text_ch.ref_start = '0;
    result_ch.ready = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: no first byte after reset, then the corner strings.
    send_str("3M", 1'b0, 1'b1, '0);
    send_str("2147483647=", 1'b1, 1'b1, '1);
    send_str("M", 1'b1, 1'b1, '0);
    send_str("5\t", 1'b1, 1'b0, 48'h0000_0000_1234);
    send_str("1", 1'b0, 1'b1, '0);
    send_str("2I 3", 1'b1, 1'b1, 48'h8000_0000_0000);
    send_str("12", 1'b1, 1'b1, '0);
    send_str(" ", 1'b1, 1'b1, '1);
    send_str("1X2D3N4S", 1'b1, 1'b1, '1 - 48'd2);

    target = sent_bytes + RAND_BYTES;
    while (sent_bytes < target) begin
      quiet = (sent_bytes >= target - 1300) && (sent_bytes < target - 1000);
      if (!drained && sent_bytes >= target - 600) begin
        drain();
        drained = 1'b1;
      end
      send_random_string();
    end
    quiet = 1'b0;

    text_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("cigar_parser_intervals_test: done, clean");
    end else begin
      $display("cigar_parser_intervals_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: cigar_parser_intervals.f
sv/cpi_pkg.sv
sv/cpi_text_if.sv
sv/cpi_result_if.sv
sv/cpi_step.sv
sv/cigar_parser_intervals.sv
test/cigar_parser_intervals_test.sv
